// ===== sv/rdmc_pkg.sv =====
// Shared types and constants of the maze carver.
package rdmc_pkg;

	localparam int SIDE_W = 6;
	localparam int CELL_W = 10;
	localparam int RND_W = 8;
	localparam int WALL_W = 4;
	localparam int CFG_W = 10;
	localparam int CFG_IDX_W = 1;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_STEP = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_SIDE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_START_CELL = 1'b1;

	localparam logic [1:0] ACT_CARVE = 2'd0;
	localparam logic [1:0] ACT_BACK = 2'd1;
	localparam logic [1:0] ACT_DONE = 2'd2;
	localparam logic [1:0] ACT_IDLE = 2'd3;

	localparam logic [1:0] DIR_N = 2'd0;
	localparam logic [1:0] DIR_E = 2'd1;
	localparam logic [1:0] DIR_S = 2'd2;
	localparam logic [1:0] DIR_W = 2'd3;

	typedef struct packed {
		logic             kind;
		logic [RND_W-1:0] rnd;
	} req_t;

	typedef struct packed {
		logic [1:0]        action;
		logic [CELL_W-1:0] from_cell;
		logic [CELL_W-1:0] to_cell;
		logic [1:0]        direction;
		logic [WALL_W-1:0] from_walls;
		logic              finished;
	} rsp_t;

endpackage

// ===== sv/rdmc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rdmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/random_dfs_maze_carver_core.sv =====
// Top level of the randomized depth-first maze carver.
//
//  Channel   Signals                          Transfer
//  -------   -------------------------------  ---------------------------------
//  request   start, busy, req (kind, rnd)     start && !busy at a rising edge
//  result    done, rsp (action .. finished)   one cycle per done pulse
//  config    cfg_we, cfg_idx, cfg_wdata       cfg_we at a rising edge
//
// A carving step keeps busy high for five reads through the single read port of
// the cell memory (four neighbours, then the current cell), a decide step and
// one write-back of the carved neighbour. A backtrack, a finish or a step on a
// finished maze ends after the decide step, with no write-back. The done pulse
// follows the decide step. A start request keeps busy high while a sweep clears
// every cell entry. After reset the same sweep runs with busy high. The result
// receiver cannot stall; each request gives one done pulse.
module random_dfs_maze_carver_core #(
	parameter int MAX_SIDE = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  rdmc_pkg::req_t                      req,
	output logic                                done,
	output rdmc_pkg::rsp_t                      rsp,
	input  logic                                cfg_we,
	input  logic [rdmc_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [rdmc_pkg::CFG_W-1:0]          cfg_wdata
);

	import rdmc_pkg::*;

	localparam int CELLS = MAX_SIDE * MAX_SIDE;
	localparam int CW = $clog2(CELLS);
	localparam int RW = $clog2(MAX_SIDE);
	localparam int LW = CW + 1;
	localparam int MARK_W = WALL_W + 1;
	localparam int SEW = CW + 2 * RW;
	localparam logic [SIDE_W-1:0] RST_SIDE = SIDE_W'((MAX_SIDE < 16) ? MAX_SIDE : 16);
	localparam logic [CW-1:0] LAST_CELL = CW'(CELLS - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_START1 = 3'd1;
	localparam logic [2:0] ST_START2 = 3'd2;
	localparam logic [2:0] ST_CLR = 3'd3;
	localparam logic [2:0] ST_SFIN = 3'd4;
	localparam logic [2:0] ST_RD = 3'd5;
	localparam logic [2:0] ST_DEC = 3'd6;
	localparam logic [2:0] ST_WR2 = 3'd7;

	logic [2:0]          state_q;
	logic [SIDE_W-1:0]   grid_side_q;
	logic [CELL_W-1:0]   start_cell_q;
	logic [SIDE_W-1:0]   side_q;
	logic [CW-1:0]       cur_q;
	logic [RW-1:0]       row_q;
	logic [RW-1:0]       col_q;
	logic [LW-1:0]       lvl_q;
	logic                fin_q;
	logic                strt_q;
	logic [CW-1:0]       clr_q;
	logic [2:0]          rd_cnt_q;
	logic [RND_W-1:0]    rnd_q;
	logic [3:0]          nbv_q;
	logic [WALL_W-1:0]   nbw_q [4];
	logic [2*SIDE_W-1:0] sq_q;
	logic [CW-1:0]       s_q;
	logic [CW-1:0]       dv_q;
	logic [CW-1:0]       quo_q;
	logic [SIDE_W-1:0]   rem_q;
	logic [CW-1:0]       wa_q;
	logic [MARK_W-1:0]   wd_q;
	logic                done_q;
	rsp_t                rsp_q;

	logic [SIDE_W-1:0]   side_clamp;
	logic                cm_we;
	logic [CW-1:0]       cm_waddr;
	logic [MARK_W-1:0]   cm_wdata;
	logic [CW-1:0]       cm_raddr;
	logic [MARK_W-1:0]   cm_rdata;
	logic                sk_we;
	logic [CW-1:0]       sk_waddr;
	logic [SEW-1:0]      sk_wdata;
	logic [CW-1:0]       sk_raddr;
	logic [SEW-1:0]      sk_rdata;
	logic [CW-1:0]       sk_cell;
	logic [RW-1:0]       sk_row;
	logic [RW-1:0]       sk_col;
	logic [3:0]          avail;
	logic [2:0]          cnt;
	logic [RND_W+2:0]    prod;
	logic [1:0]          pick;
	logic [1:0]          sel_dir;
	logic                carve;
	logic [WALL_W-1:0]   fw;
	logic [WALL_W-1:0]   fw_new;
	logic [CW-1:0]       n_cell;
	logic [RW-1:0]       n_row;
	logic [RW-1:0]       n_col;
	logic [SIDE_W:0]     rem_n;
	logic                div_ge;
	logic [SIDE_W:0]     rem_sub;
	logic [CW-1:0]       s_fix;

	function automatic logic [CW-1:0] nb_addr(input logic [1:0] d, input logic [CW-1:0] c,
			input logic [SIDE_W-1:0] s);
		logic [CW-1:0] sc;
		sc = CW'(s);
		case (d)
			DIR_N: nb_addr = c - sc;
			DIR_E: nb_addr = c + CW'(1);
			DIR_S: nb_addr = c + sc;
			default: nb_addr = c - CW'(1);
		endcase
	endfunction

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp = rsp_q;

	always_comb begin
		if (grid_side_q < SIDE_W'(2)) begin
			side_clamp = SIDE_W'(2);
		end else if (int'(grid_side_q) > MAX_SIDE) begin
			side_clamp = SIDE_W'(MAX_SIDE);
		end else begin
			side_clamp = grid_side_q;
		end
	end

	assign s_fix = (int'(start_cell_q) >= int'(sq_q)) ? '0 : CW'(start_cell_q);

	assign rem_n = {rem_q, dv_q[CW-1]};
	assign div_ge = (rem_n >= {1'b0, side_q});
	assign rem_sub = rem_n - {1'b0, side_q};

	assign sk_cell = sk_rdata[SEW-1 -: CW];
	assign sk_row = sk_rdata[2*RW-1 -: RW];
	assign sk_col = sk_rdata[RW-1:0];
	assign sk_raddr = CW'(lvl_q - LW'(2));

	assign avail[0] = (row_q != '0) && !nbv_q[0];
	assign avail[1] = (int'(col_q) + 1 < int'(side_q)) && !nbv_q[1];
	assign avail[2] = (int'(row_q) + 1 < int'(side_q)) && !nbv_q[2];
	assign avail[3] = (col_q != '0) && !nbv_q[3];
	assign cnt = 3'($countones(avail));
	assign prod = (RND_W+3)'(rnd_q) * (RND_W+3)'(cnt);
	assign pick = prod[RND_W+1:RND_W];
	assign carve = |avail;

	always_comb begin
		logic [2:0] k;
		k = '0;
		sel_dir = DIR_N;
		for (int d = 0; d < 4; d++) begin
			if (avail[d]) begin
				if (k == {1'b0, pick}) begin
					sel_dir = 2'(d);
				end
				k = k + 3'd1;
			end
		end
	end

	assign fw = cm_rdata[WALL_W-1:0];
	assign fw_new = carve ? (fw & ~(WALL_W'(1) << sel_dir)) : fw;
	assign n_cell = nb_addr(sel_dir, cur_q, side_q);

	always_comb begin
		n_row = row_q;
		n_col = col_q;
		case (sel_dir)
			DIR_N: n_row = row_q - RW'(1);
			DIR_E: n_col = col_q + RW'(1);
			DIR_S: n_row = row_q + RW'(1);
			default: n_col = col_q - RW'(1);
		endcase
	end

	assign cm_raddr = (rd_cnt_q < 3'd4) ? nb_addr(rd_cnt_q[1:0], cur_q, side_q) : cur_q;

	always_comb begin
		cm_we = 1'b0;
		cm_waddr = cur_q;
		cm_wdata = {1'b1, fw_new};
		sk_we = 1'b0;
		sk_waddr = CW'(lvl_q);
		sk_wdata = {n_cell, n_row, n_col};
		unique case (state_q)
			ST_CLR: begin
				cm_we = 1'b1;
				cm_waddr = clr_q;
				cm_wdata = {1'b0, {WALL_W{1'b1}}};
			end
			ST_DEC: begin
				cm_we = !fin_q;
				sk_we = !fin_q && carve && (int'(lvl_q) < CELLS);
			end
			ST_WR2: begin
				cm_we = 1'b1;
				cm_waddr = wa_q;
				cm_wdata = wd_q;
			end
			ST_SFIN: begin
				sk_we = 1'b1;
				sk_waddr = '0;
				sk_wdata = {s_q, RW'(quo_q), RW'(rem_q)};
			end
			default: begin
			end
		endcase
	end

	rdmc_ram #(.WIDTH(MARK_W), .DEPTH(CELLS)) u_cell_ram (
		.clk   (clk),
		.we    (cm_we),
		.waddr (cm_waddr),
		.wdata (cm_wdata),
		.raddr (cm_raddr),
		.rdata (cm_rdata)
	);

	rdmc_ram #(.WIDTH(SEW), .DEPTH(CELLS)) u_stack_ram (
		.clk   (clk),
		.we    (sk_we),
		.waddr (sk_waddr),
		.wdata (sk_wdata),
		.raddr (sk_raddr),
		.rdata (sk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_side_q <= SIDE_W'(16);
			start_cell_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_GRID_SIDE: grid_side_q <= cfg_wdata[SIDE_W-1:0];
				REG_START_CELL: start_cell_q <= cfg_wdata[CELL_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			side_q <= RST_SIDE;
			cur_q <= '0;
			row_q <= '0;
			col_q <= '0;
			lvl_q <= '0;
			fin_q <= 1'b1;
			strt_q <= 1'b0;
			clr_q <= '0;
			rd_cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (req.kind == KIND_START) begin
							side_q <= side_clamp;
							state_q <= ST_START1;
						end else begin
							rd_cnt_q <= '0;
							state_q <= ST_RD;
						end
					end
				end
				ST_START1: begin
					state_q <= ST_START2;
				end
				ST_START2: begin
					strt_q <= 1'b1;
					clr_q <= '0;
					state_q <= ST_CLR;
				end
				ST_CLR: begin
					clr_q <= clr_q + CW'(1);
					if (clr_q == LAST_CELL) begin
						state_q <= strt_q ? ST_SFIN : ST_IDLE;
					end
				end
				ST_SFIN: begin
					cur_q <= s_q;
					row_q <= RW'(quo_q);
					col_q <= RW'(rem_q);
					lvl_q <= LW'(1);
					fin_q <= 1'b0;
					strt_q <= 1'b0;
					done_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_RD: begin
					rd_cnt_q <= rd_cnt_q + 3'd1;
					if (rd_cnt_q == 3'd4) begin
						state_q <= ST_DEC;
					end
				end
				ST_DEC: begin
					done_q <= 1'b1;
					state_q <= ST_IDLE;
					if (!fin_q) begin
						if (carve) begin
							cur_q <= n_cell;
							row_q <= n_row;
							col_q <= n_col;
							if (int'(lvl_q) < CELLS) begin
								lvl_q <= lvl_q + LW'(1);
							end
							state_q <= ST_WR2;
						end else if (lvl_q > LW'(1)) begin
							cur_q <= sk_cell;
							row_q <= sk_row;
							col_q <= sk_col;
							lvl_q <= lvl_q - LW'(1);
						end else begin
							lvl_q <= '0;
							fin_q <= 1'b1;
						end
					end
				end
				ST_WR2: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			rnd_q <= req.rnd;
		end
		if (state_q == ST_START1) begin
			sq_q <= (2*SIDE_W)'(side_q) * (2*SIDE_W)'(side_q);
		end
		if (state_q == ST_START2) begin
			s_q <= s_fix;
			dv_q <= s_fix;
			quo_q <= '0;
			rem_q <= '0;
		end
		if (state_q == ST_CLR && int'(clr_q) < CW) begin
			dv_q <= {dv_q[CW-2:0], 1'b0};
			quo_q <= {quo_q[CW-2:0], div_ge};
			rem_q <= div_ge ? SIDE_W'(rem_sub) : SIDE_W'(rem_n);
		end
		if (state_q == ST_RD && rd_cnt_q != 3'd0) begin
			nbv_q[2'(rd_cnt_q - 3'd1)] <= cm_rdata[WALL_W];
			nbw_q[2'(rd_cnt_q - 3'd1)] <= cm_rdata[WALL_W-1:0];
		end
		if (state_q == ST_DEC) begin
			wa_q <= n_cell;
			wd_q <= {nbv_q[sel_dir], nbw_q[sel_dir] & ~(WALL_W'(1) << (sel_dir ^ 2'b10))};
			rsp_q.from_cell <= CELL_W'(cur_q);
			rsp_q.direction <= DIR_N;
			if (fin_q) begin
				rsp_q.action <= ACT_IDLE;
				rsp_q.to_cell <= CELL_W'(cur_q);
				rsp_q.from_walls <= fw;
				rsp_q.finished <= 1'b1;
			end else if (carve) begin
				rsp_q.action <= ACT_CARVE;
				rsp_q.to_cell <= CELL_W'(n_cell);
				rsp_q.direction <= sel_dir;
				rsp_q.from_walls <= fw_new;
				rsp_q.finished <= 1'b0;
			end else if (lvl_q > LW'(1)) begin
				rsp_q.action <= ACT_BACK;
				rsp_q.to_cell <= CELL_W'(sk_cell);
				rsp_q.from_walls <= fw;
				rsp_q.finished <= 1'b0;
			end else begin
				rsp_q.action <= ACT_DONE;
				rsp_q.to_cell <= CELL_W'(cur_q);
				rsp_q.from_walls <= fw;
				rsp_q.finished <= 1'b1;
			end
		end
		if (state_q == ST_SFIN) begin
			rsp_q.action <= ACT_CARVE;
			rsp_q.from_cell <= CELL_W'(cur_q);
			rsp_q.to_cell <= CELL_W'(s_q);
			rsp_q.direction <= DIR_N;
			rsp_q.from_walls <= {WALL_W{1'b1}};
			rsp_q.finished <= 1'b0;
		end
	end

endmodule

// ===== sv/rdmc_checker.sv =====
// Port-level checks of the maze carver and the bind that attaches them.
module rdmc_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input rdmc_pkg::rsp_t rsp
);

	import rdmc_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("An accepted request did not raise busy.");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("A result appeared with no request in progress.");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("Two results followed back to back.");

	a_finished_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.finished == (rsp.action == ACT_DONE || rsp.action == ACT_IDLE)))
		else $error("The finished flag disagrees with the action.");

	a_stay_put: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.action == ACT_DONE || rsp.action == ACT_IDLE))
			|-> (rsp.from_cell == rsp.to_cell && rsp.direction == DIR_N))
		else $error("A finishing result moved to another cell.");

endmodule

bind random_dfs_maze_carver_core rdmc_checker u_rdmc_checker (.*);

// ===== tb/random_dfs_maze_carver_core_tb.sv =====
// Testbench of the maze carver: directed and random mazes checked against a cell-level predictor.
module random_dfs_maze_carver_core_tb;
	import rdmc_pkg::*;

	localparam int MAX_SIDE = 32;
	localparam int CELLS = MAX_SIDE * MAX_SIDE;
	localparam int ITEMS = 1450;
	localparam int CALM_TAIL = 120;
	localparam int REQ_W = $bits(req_t);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	class maze_scoreboard;
		bit seen[CELLS];
		logic [WALL_W-1:0] walls[CELLS];
		logic [CELL_W-1:0] trail[CELLS];
		int depth;
		logic [CELL_W-1:0] here;
		bit complete;
		int side_in_use;
		logic [SIDE_W-1:0] side_reg;
		logic [CELL_W-1:0] start_reg;
		rsp_t pending[$];
		int errors;

		function new();
			foreach (seen[i]) begin
				seen[i] = 1'b0;
				walls[i] = '1;
				trail[i] = '0;
			end
			depth = 0;
			here = '0;
			complete = 1'b1;
			side_reg = 6'd16;
			start_reg = '0;
			side_in_use = 16;
			errors = 0;
		endfunction

		function int limit_side(int s);
			if (s < 2)
				return 2;
			if (s > MAX_SIDE)
				return MAX_SIDE;
			return s;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
			if (idx == REG_GRID_SIDE)
				side_reg = value[SIDE_W-1:0];
			else if (idx == REG_START_CELL)
				start_reg = value[CELL_W-1:0];
		endfunction

		// Works out the result of one accepted request and queues it.
		function void note(req_t r);
			rsp_t want;
			int row, col, count, pick, target, origin;
			int cand[4];
			logic [1:0] cdir[4];
			logic [1:0] way, back_way;
			origin = here;
			want.from_cell = here;
			want.direction = DIR_N;
			if (r.kind == KIND_START) begin
				side_in_use = limit_side(side_reg);
				target = start_reg;
				if (target >= side_in_use * side_in_use)
					target = 0;
				foreach (seen[i]) begin
					seen[i] = 1'b0;
					walls[i] = '1;
				end
				trail[0] = CELL_W'(target);
				depth = 1;
				here = CELL_W'(target);
				complete = 1'b0;
				want.action = ACT_CARVE;
				want.to_cell = CELL_W'(target);
				want.from_walls = '1;
				want.finished = 1'b0;
			end else if (complete) begin
				want.action = ACT_IDLE;
				want.to_cell = here;
				want.from_walls = walls[here];
				want.finished = 1'b1;
			end else begin
				row = origin / side_in_use;
				col = origin % side_in_use;
				seen[origin] = 1'b1;
				count = 0;
				if (row > 0 && !seen[origin - side_in_use]) begin
					cand[count] = origin - side_in_use;
					cdir[count] = DIR_N;
					count++;
				end
				if (col + 1 < side_in_use && !seen[origin + 1]) begin
					cand[count] = origin + 1;
					cdir[count] = DIR_E;
					count++;
				end
				if (row + 1 < side_in_use && !seen[origin + side_in_use]) begin
					cand[count] = origin + side_in_use;
					cdir[count] = DIR_S;
					count++;
				end
				if (col > 0 && !seen[origin - 1]) begin
					cand[count] = origin - 1;
					cdir[count] = DIR_W;
					count++;
				end
				if (count > 0) begin
					pick = (int'(r.rnd) * count) >> 8;
					way = cdir[pick];
					back_way = way + 2'd2;
					target = cand[pick];
					walls[origin][way] = 1'b0;
					walls[target][back_way] = 1'b0;
					if (depth < CELLS) begin
						trail[depth] = CELL_W'(target);
						depth++;
					end
					here = CELL_W'(target);
					want.action = ACT_CARVE;
					want.to_cell = CELL_W'(target);
					want.direction = way;
					want.from_walls = walls[origin];
					want.finished = 1'b0;
				end else if (depth > 1) begin
					depth--;
					here = trail[depth - 1];
					want.action = ACT_BACK;
					want.to_cell = here;
					want.from_walls = walls[origin];
					want.finished = 1'b0;
				end else begin
					depth = 0;
					complete = 1'b1;
					want.action = ACT_DONE;
					want.to_cell = CELL_W'(origin);
					want.from_walls = walls[origin];
					want.finished = 1'b1;
				end
			end
			pending = {pending, want};
		endfunction

		task report(string msg);
			if (errors < 40)
				$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task compare_field(string name, int got, int want);
			if (got != want)
				report($sformatf("%s got %0h expected %0h", name, got, want));
		endtask

		task check(rsp_t got);
			rsp_t want;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result %p", got));
				return;
			end
			want = pending.pop_front();
			compare_field("action", got.action, want.action);
			compare_field("from_cell", got.from_cell, want.from_cell);
			compare_field("to_cell", got.to_cell, want.to_cell);
			compare_field("direction", got.direction, want.direction);
			compare_field("from_walls", got.from_walls, want.from_walls);
			compare_field("finished", got.finished, want.finished);
		endtask
	endclass

	maze_scoreboard board;
	int sent = 0;
	bit calm = 1'b0;

	random_dfs_maze_carver_core #(
		.MAX_SIDE(MAX_SIDE)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			board.check(rsp);
	end

	task automatic hold_off();
		int n;
		if (calm || sent >= ITEMS - CALM_TAIL || $urandom_range(0, 2) != 0)
			return;
		n = $urandom_range(1, 13);
		start <= 1'b0;
		req <= REQ_W'($urandom);
		repeat (n) @(posedge clk);
	endtask

	task automatic send(logic kind, logic [RND_W-1:0] rnd);
		req_t item;
		item.kind = kind;
		item.rnd = rnd;
		hold_off();
		start <= 1'b1;
		req <= item;
		do @(posedge clk); while (busy);
		board.note(item);
		sent++;
	endtask

	task automatic settle();
		start <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		board.write_reg(idx, value);
		cfg_we <= 1'b0;
		cfg_idx <= CFG_IDX_W'($urandom);
		cfg_wdata <= CFG_W'($urandom);
		@(posedge clk);
	endtask

	initial begin
		int pick, side_val, span, steps, mid;
		logic [CFG_W-1:0] cfg_value;
		board = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);

		// A step before any maze has been started reports the idle state.
		send(KIND_STEP, 8'hFF);
		settle();
		set_reg(REG_GRID_SIDE, 10'd1);
		set_reg(REG_START_CELL, 10'd3);
		send(KIND_START, 8'h00);
		for (int k = 0; k < 8; k++)
			send(KIND_STEP, k[0] ? 8'hFF : 8'h00);
		settle();
		set_reg(REG_GRID_SIDE, 10'h3FF);
		set_reg(REG_START_CELL, 10'h3FF);
		send(KIND_START, 8'hFF);
		send(KIND_STEP, 8'h80);
		send(KIND_STEP, 8'h7F);
		send(KIND_STEP, 8'h55);
		send(KIND_STEP, 8'hAA);
		settle();
		set_reg(REG_GRID_SIDE, 10'd3);
		set_reg(REG_START_CELL, 10'd9);
		send(KIND_START, 8'h5A);
		repeat (3) send(KIND_STEP, RND_W'($urandom));
		// A new side only takes hold at the next start request.
		settle();
		set_reg(REG_GRID_SIDE, 10'd2);
		repeat (3) send(KIND_STEP, RND_W'($urandom));
		send(KIND_START, RND_W'($urandom));
		repeat (2) send(KIND_STEP, RND_W'($urandom));

		while (sent < ITEMS) begin
			settle();
			pick = $urandom_range(0, 19);
			if (pick == 0)
				side_val = $urandom_range(32, 63);
			else if (pick == 1)
				side_val = $urandom_range(0, 1);
			else if (pick < 5)
				side_val = $urandom_range(7, 12);
			else
				side_val = $urandom_range(2, 6);
			span = board.limit_side(side_val);
			cfg_value = CFG_W'($urandom);
			cfg_value[SIDE_W-1:0] = SIDE_W'(side_val);
			set_reg(REG_GRID_SIDE, cfg_value);
			if ($urandom_range(0, 3) != 0) begin
				if ($urandom_range(0, 5) == 0)
					set_reg(REG_START_CELL, CFG_W'($urandom_range(0, CELLS - 1)));
				else
					set_reg(REG_START_CELL, CFG_W'($urandom_range(0, span * span - 1)));
			end
			calm = ($urandom_range(0, 3) == 0);
			send(KIND_START, RND_W'($urandom));
			steps = 2 * span * span - 1 + $urandom_range(0, 2);
			if ($urandom_range(0, 5) == 0)
				steps = $urandom_range(1, steps);
			if (steps > 300)
				steps = $urandom_range(100, 300);
			mid = ($urandom_range(0, 4) == 0) ? $urandom_range(1, steps) : 0;
			for (int k = 1; k <= steps && sent < ITEMS; k++) begin
				if (k == mid) begin
					settle();
					set_reg(REG_GRID_SIDE, CFG_W'($urandom));
				end
				send(KIND_STEP, RND_W'($urandom));
			end
		end

		settle();
		repeat (20) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#4000000;
		$display("Verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/rdmc_pkg.sv
sv/rdmc_ram.sv
sv/random_dfs_maze_carver_core.sv
sv/rdmc_checker.sv
tb/random_dfs_maze_carver_core_tb.sv
